### hdl/rrd_pkg.sv
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types and constants of the ray reflect/refract direction unit.
// ----------------------------------------------------------------------------
package rrd_pkg;

    localparam int IDX_W    = 16;
    localparam int IDX_FRAC = 12;

    localparam logic CMD_REFLECT = 1'b0;
    localparam logic CMD_REFRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIR     = 2'd1,
        ST_INVALID = 2'd2,
        ST_SAT     = 2'd3
    } status_t;

endpackage

### hdl/rrd_div_cell.sv
// ----------------------------------------------------------------------------
// rrd_div_cell
// One restoring-division cell: resolves one quotient bit per enabled cycle.
// ----------------------------------------------------------------------------
module rrd_div_cell #(
    parameter int DW     = 16,
    parameter int QW     = 27,
    parameter int IDX    = 0,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  logic [DW-1:0]     dvs_in,
    input  logic [DW-1:0]     rem_in,
    input  logic [QW-1:0]     quo_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output logic [DW-1:0]     dvs_out,
    output logic [DW-1:0]     rem_out,
    output logic [QW-1:0]     quo_out,
    output logic [SIDE_W-1:0] side_out
);
    import rrd_pkg::*;

    // dividend is a single one at the top quotient position
    localparam logic DBIT = (IDX == QW - 1);

    logic              vld_reg;
    logic [DW-1:0]     dvs_reg;
    logic [DW-1:0]     rem_reg;
    logic [QW-1:0]     quo_reg;
    logic [SIDE_W-1:0] side_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_in, DBIT};
        diff     = trial - {1'b0, dvs_in};
        ge       = (trial >= {1'b0, dvs_in});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_next = {quo_in[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvs_reg  <= dvs_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign dvs_out  = dvs_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

### hdl/rrd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rrd_sqrt_cell
// One integer square root cell: resolves one root bit per enabled cycle.
// ----------------------------------------------------------------------------
module rrd_sqrt_cell #(
    parameter int SR     = 34,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  logic [2*SR-1:0]   x_in,
    input  logic [SR-1:0]     root_in,
    input  logic [SR+1:0]     rem_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output logic [2*SR-1:0]   x_out,
    output logic [SR-1:0]     root_out,
    output logic [SR+1:0]     rem_out,
    output logic [SIDE_W-1:0] side_out
);
    import rrd_pkg::*;

    localparam int XW = 2 * SR;

    logic              vld_reg;
    logic [XW-1:0]     x_reg;
    logic [SR-1:0]     root_reg;
    logic [SR+1:0]     rem_reg;
    logic [SIDE_W-1:0] side_reg;

    logic [SR+3:0] cur;
    logic [SR+3:0] trial;
    logic [SR+3:0] diff;
    logic          ge;
    logic [SR+1:0] rem_next;
    logic [SR-1:0] root_next;
    logic [XW-1:0] x_next;

    always_comb
    begin
        cur       = {rem_in, x_in[XW-1:XW-2]};
        trial     = (SR+4)'({root_in, 2'b01});
        diff      = cur - trial;
        ge        = (cur >= trial);
        rem_next  = ge ? diff[SR+1:0] : cur[SR+1:0];
        root_next = {root_in[SR-2:0], ge};
        x_next    = {x_in[XW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;
    assign side_out = side_reg;

endmodule

### hdl/ray_reflect_refract_direction.sv
// ----------------------------------------------------------------------------
// ray_reflect_refract_direction
// Reflects or refracts a fixed-point ray direction at a surface.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries cmd, direction, normal and the
// relative index; output channel (out_valid/out_ready) carries the new
// direction and a status code. One result per input transfer, in order.
// Throughput: one transfer per cycle while out_ready is high.
// The pipeline has FRAC_BITS + 13 divider cells, one root cell per result
// bit of the square root and 14 stages of multiply/add.
// The reciprocal of the index comes from the divider cell row, sqrt(k) from
// the root cell row; both rows advance with the rest of the pipeline.
// The whole pipeline advances as one: when the output register holds a
// result that is not taken, every stage holds and in_ready is low.
// Reset clears all valid bits; the pipeline is empty and in_ready is high.
// Status: 0 ok, 1 total internal reflection (zero vector), 2 zero index on
// refract (zero vector), 3 result clamped to the component range.
// ----------------------------------------------------------------------------
module ray_reflect_refract_direction #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic signed [COMP_WIDTH-1:0] dir_x,
    input  logic signed [COMP_WIDTH-1:0] dir_y,
    input  logic signed [COMP_WIDTH-1:0] dir_z,
    input  logic signed [COMP_WIDTH-1:0] norm_x,
    input  logic signed [COMP_WIDTH-1:0] norm_y,
    input  logic signed [COMP_WIDTH-1:0] norm_z,
    input  logic [rrd_pkg::IDX_W-1:0]    index_ratio,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COMP_WIDTH-1:0] out_x,
    output logic signed [COMP_WIDTH-1:0] out_y,
    output logic signed [COMP_WIDTH-1:0] out_z,
    output logic [1:0]                   status
);
    import rrd_pkg::*;

    localparam int W    = COMP_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int DOTW = 2 * W - F + 2;
    localparam int NW   = W + 1;
    localparam int DNW  = DOTW + 1;
    localparam int QW   = F + IDX_FRAC + 1;
    localparam int AAW  = 2 * QW - F;
    localparam int NNW  = 2 * DOTW - F;
    localparam int TW   = NNW + 1;
    localparam int AL   = AAW / 2;
    localparam int AH   = AAW - AL;
    localparam int KLW  = AL + 1 + TW;
    localparam int KHW  = AH + 1 + TW;
    localparam int KPW  = AAW + TW + 1;
    localparam int KTW  = KPW - F;
    localparam int KW   = KTW + 1;
    localparam int SR   = (KW - 1 + F + 1) / 2;
    localparam int XW   = 2 * SR;
    localparam int NVAW = DOTW + QW + 1;
    localparam int NVTW = NVAW - F;
    localparam int BW   = ((NVTW > SR + 1) ? NVTW : SR + 1) + 1;
    localparam int NBW  = NW + BW;
    localparam int NBTW = NBW - F;
    localparam int DAW  = W + QW + 1;
    localparam int XVW  = DAW - F;
    localparam int RW   = NBTW + 2;

    localparam int S1W = 2 + 3 * W + 3 * NW + DOTW + DNW;
    localparam int S2W = 3 + 3 * NW + 3 * XVW + BW + DNW;

    localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< F;
    localparam logic signed [KW-1:0] ONE_K = KW'(1) <<< F;
    localparam logic signed [RW-1:0] OUT_HI = RW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [RW-1:0] OUT_LO = -OUT_HI - RW'(1);

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: products for the dot product ----------------
    logic signed [W-1:0] d_in [3];
    logic signed [W-1:0] n_in [3];

    assign d_in[0] = dir_x;
    assign d_in[1] = dir_y;
    assign d_in[2] = dir_z;
    assign n_in[0] = norm_x;
    assign n_in[1] = norm_y;
    assign n_in[2] = norm_z;

    logic                 s1_vld_reg;
    logic                 s1_cmd_reg;
    logic [IDX_W-1:0]     s1_p_reg;
    logic signed [W-1:0]  s1_d_reg [3];
    logic signed [W-1:0]  s1_n_reg [3];
    logic signed [PW-1:0] s1_pr_reg [3];

    // ---------------- stage 2: dot product ----------------
    logic                   s2_vld_reg;
    logic                   s2_cmd_reg;
    logic [IDX_W-1:0]       s2_p_reg;
    logic signed [W-1:0]    s2_d_reg [3];
    logic signed [W-1:0]    s2_n_reg [3];
    logic signed [DOTW-1:0] s2_dot_reg;
    logic signed [PW-1:0]   pr_b [3];
    logic signed [PW-F-1:0] pr_t [3];
    logic signed [DOTW-1:0] dot_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pr_b[i] = s1_pr_reg[i] + $signed(PW'({F{s1_pr_reg[i][PW-1]}}));
            pr_t[i] = pr_b[i][PW-1:F];
        end
        dot_next = DOTW'(pr_t[0]) + DOTW'(pr_t[1]) + DOTW'(pr_t[2]);
    end

    // ---------------- stage 3: normal flip ----------------
    logic                   s3_vld_reg;
    logic                   s3_cmd_reg;
    logic                   s3_zero_reg;
    logic [IDX_W-1:0]       s3_p_reg;
    logic signed [W-1:0]    s3_d_reg [3];
    logic signed [NW-1:0]   s3_n_reg [3];
    logic signed [DOTW-1:0] s3_nv_reg;
    logic signed [DNW-1:0]  s3_dn2_reg;
    logic                   flip;

    assign flip = (s2_cmd_reg == CMD_REFRACT) && (s2_dot_reg > 0);

    // ---------------- divider cell row: a = 2^(F+12) / p ----------------
    logic             dc_vld  [QW+1];
    logic [IDX_W-1:0] dc_dvs  [QW+1];
    logic [IDX_W-1:0] dc_rem  [QW+1];
    logic [QW-1:0]    dc_quo  [QW+1];
    logic [S1W-1:0]   dc_side [QW+1];

    assign dc_vld[0]  = s3_vld_reg;
    assign dc_dvs[0]  = s3_p_reg;
    assign dc_rem[0]  = '0;
    assign dc_quo[0]  = '0;
    assign dc_side[0] = {s3_cmd_reg, s3_zero_reg,
                         s3_d_reg[2], s3_d_reg[1], s3_d_reg[0],
                         s3_n_reg[2], s3_n_reg[1], s3_n_reg[0],
                         s3_nv_reg, s3_dn2_reg};

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        rrd_div_cell #(
            .DW     (IDX_W),
            .QW     (QW),
            .IDX    (QW - 1 - g),
            .SIDE_W (S1W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (dc_vld[g]),
            .dvs_in   (dc_dvs[g]),
            .rem_in   (dc_rem[g]),
            .quo_in   (dc_quo[g]),
            .side_in  (dc_side[g]),
            .vld_out  (dc_vld[g+1]),
            .dvs_out  (dc_dvs[g+1]),
            .rem_out  (dc_rem[g+1]),
            .quo_out  (dc_quo[g+1]),
            .side_out (dc_side[g+1])
        );
    end

    logic                   c4_cmd;
    logic                   c4_zero;
    logic signed [W-1:0]    c4_d [3];
    logic signed [NW-1:0]   c4_n [3];
    logic signed [DOTW-1:0] c4_nv;
    logic signed [DNW-1:0]  c4_dn2;
    logic signed [QW:0]     c4_a;

    assign {c4_cmd, c4_zero, c4_d[2], c4_d[1], c4_d[0],
            c4_n[2], c4_n[1], c4_n[0], c4_nv, c4_dn2} = dc_side[QW];
    assign c4_a = $signed({1'b0, dc_quo[QW]});

    // ---------------- stage 5: products with a ----------------
    logic                       s5_vld_reg;
    logic                       s5_cmd_reg;
    logic                       s5_zero_reg;
    logic signed [W-1:0]        s5_d_reg [3];
    logic signed [NW-1:0]       s5_n_reg [3];
    logic signed [DNW-1:0]      s5_dn2_reg;
    logic [2*QW-1:0]            s5_aa_reg;
    logic signed [2*DOTW-1:0]   s5_nn_reg;
    logic signed [DAW-1:0]      s5_da_reg [3];
    logic signed [NVAW-1:0]     s5_nva_reg;

    // ---------------- stage 6: truncation, 1 - nv^2 ----------------
    logic                    s6_vld_reg;
    logic                    s6_cmd_reg;
    logic                    s6_zero_reg;
    logic signed [NW-1:0]    s6_n_reg [3];
    logic signed [DNW-1:0]   s6_dn2_reg;
    logic [AAW-1:0]          s6_aa_reg;
    logic signed [TW-1:0]    s6_t_reg;
    logic signed [XVW-1:0]   s6_x_reg [3];
    logic signed [BW-1:0]    s6_nva_reg;
    logic signed [DAW-1:0]   da_b [3];
    logic signed [XVW-1:0]   x_next [3];
    logic signed [NVAW-1:0]  nva_b;
    logic signed [NVTW-1:0]  nva_t;
    logic signed [TW-1:0]    t_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            da_b[i]   = s5_da_reg[i] + $signed(DAW'({F{s5_da_reg[i][DAW-1]}}));
            x_next[i] = (s5_cmd_reg == CMD_REFRACT) ? da_b[i][DAW-1:F]
                                                    : XVW'(s5_d_reg[i]);
        end
        nva_b  = s5_nva_reg + $signed(NVAW'({F{s5_nva_reg[NVAW-1]}}));
        nva_t  = nva_b[NVAW-1:F];
        t_next = ONE_T - $signed({1'b0, s5_nn_reg[2*DOTW-1:F]});
    end

    // ---------------- stage 7: split product aa * t ----------------
    logic                  s7_vld_reg;
    logic                  s7_cmd_reg;
    logic                  s7_zero_reg;
    logic signed [NW-1:0]  s7_n_reg [3];
    logic signed [DNW-1:0] s7_dn2_reg;
    logic signed [XVW-1:0] s7_x_reg [3];
    logic signed [BW-1:0]  s7_nva_reg;
    logic signed [KLW-1:0] s7_kl_reg;
    logic signed [KHW-1:0] s7_kh_reg;

    // ---------------- stage 8: recombine ----------------
    logic                  s8_vld_reg;
    logic                  s8_cmd_reg;
    logic                  s8_zero_reg;
    logic signed [NW-1:0]  s8_n_reg [3];
    logic signed [DNW-1:0] s8_dn2_reg;
    logic signed [XVW-1:0] s8_x_reg [3];
    logic signed [BW-1:0]  s8_nva_reg;
    logic signed [KPW-1:0] s8_kp_reg;

    // ---------------- stage 9: truncate ----------------
    logic                  s9_vld_reg;
    logic                  s9_cmd_reg;
    logic                  s9_zero_reg;
    logic signed [NW-1:0]  s9_n_reg [3];
    logic signed [DNW-1:0] s9_dn2_reg;
    logic signed [XVW-1:0] s9_x_reg [3];
    logic signed [BW-1:0]  s9_nva_reg;
    logic signed [KTW-1:0] s9_kt_reg;
    logic signed [KPW-1:0] kp_b;

    assign kp_b = s8_kp_reg + $signed(KPW'({F{s8_kp_reg[KPW-1]}}));

    // ---------------- stage 10: k and root operand ----------------
    logic                  s10_vld_reg;
    logic                  s10_cmd_reg;
    logic                  s10_zero_reg;
    logic                  s10_tir_reg;
    logic signed [NW-1:0]  s10_n_reg [3];
    logic signed [DNW-1:0] s10_dn2_reg;
    logic signed [XVW-1:0] s10_x_reg [3];
    logic signed [BW-1:0]  s10_nva_reg;
    logic [XW-1:0]         s10_op_reg;
    logic signed [KW-1:0]  k_next;

    assign k_next = ONE_K - KW'(s9_kt_reg);

    // ---------------- root cell row: sqrt(k << F) ----------------
    logic           sc_vld  [SR+1];
    logic [XW-1:0]  sc_x    [SR+1];
    logic [SR-1:0]  sc_root [SR+1];
    logic [SR+1:0]  sc_rem  [SR+1];
    logic [S2W-1:0] sc_side [SR+1];

    assign sc_vld[0]  = s10_vld_reg;
    assign sc_x[0]    = s10_op_reg;
    assign sc_root[0] = '0;
    assign sc_rem[0]  = '0;
    assign sc_side[0] = {s10_cmd_reg, s10_zero_reg, s10_tir_reg,
                         s10_n_reg[2], s10_n_reg[1], s10_n_reg[0],
                         s10_x_reg[2], s10_x_reg[1], s10_x_reg[0],
                         s10_nva_reg, s10_dn2_reg};

    for (genvar g = 0; g < SR; g++)
    begin : g_sqrt
        rrd_sqrt_cell #(
            .SR     (SR),
            .SIDE_W (S2W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (sc_vld[g]),
            .x_in     (sc_x[g]),
            .root_in  (sc_root[g]),
            .rem_in   (sc_rem[g]),
            .side_in  (sc_side[g]),
            .vld_out  (sc_vld[g+1]),
            .x_out    (sc_x[g+1]),
            .root_out (sc_root[g+1]),
            .rem_out  (sc_rem[g+1]),
            .side_out (sc_side[g+1])
        );
    end

    logic                  c11_cmd;
    logic                  c11_zero;
    logic                  c11_tir;
    logic signed [NW-1:0]  c11_n [3];
    logic signed [XVW-1:0] c11_x [3];
    logic signed [BW-1:0]  c11_nva;
    logic signed [DNW-1:0] c11_dn2;
    logic signed [BW-1:0]  b_next;

    assign {c11_cmd, c11_zero, c11_tir, c11_n[2], c11_n[1], c11_n[0],
            c11_x[2], c11_x[1], c11_x[0], c11_nva, c11_dn2} = sc_side[SR];
    assign b_next = (c11_cmd == CMD_REFRACT)
                  ? c11_nva + $signed(BW'({1'b0, sc_root[SR]}))
                  : BW'(c11_dn2);

    // ---------------- stage 11: b ----------------
    logic                  s11_vld_reg;
    logic                  s11_cmd_reg;
    logic                  s11_zero_reg;
    logic                  s11_tir_reg;
    logic signed [NW-1:0]  s11_n_reg [3];
    logic signed [XVW-1:0] s11_x_reg [3];
    logic signed [BW-1:0]  s11_b_reg;

    // ---------------- stage 12: n * b ----------------
    logic                  s12_vld_reg;
    logic                  s12_cmd_reg;
    logic                  s12_zero_reg;
    logic                  s12_tir_reg;
    logic signed [XVW-1:0] s12_x_reg [3];
    logic signed [NBW-1:0] s12_nb_reg [3];

    // ---------------- stage 13: truncate ----------------
    logic                   s13_vld_reg;
    logic                   s13_cmd_reg;
    logic                   s13_zero_reg;
    logic                   s13_tir_reg;
    logic signed [XVW-1:0]  s13_x_reg [3];
    logic signed [NBTW-1:0] s13_nbt_reg [3];
    logic signed [NBW-1:0]  nb_b [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nb_b[i] = s12_nb_reg[i] + $signed(NBW'({F{s12_nb_reg[i][NBW-1]}}));
        end
    end

    // ---------------- stage 14: difference ----------------
    logic                 s14_vld_reg;
    logic                 s14_cmd_reg;
    logic                 s14_zero_reg;
    logic                 s14_tir_reg;
    logic signed [RW-1:0] s14_r_reg [3];

    // ---------------- output: clamp and status ----------------
    logic signed [W-1:0] out_c_reg [3];
    status_t             status_reg;
    logic signed [W-1:0] clamp_next [3];
    logic [2:0]          ovf;
    status_t             status_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ovf[i] = (s14_r_reg[i] > OUT_HI) || (s14_r_reg[i] < OUT_LO);
            if (s14_r_reg[i] > OUT_HI)
            begin
                clamp_next[i] = OUT_HI[W-1:0];
            end
            else if (s14_r_reg[i] < OUT_LO)
            begin
                clamp_next[i] = OUT_LO[W-1:0];
            end
            else
            begin
                clamp_next[i] = s14_r_reg[i][W-1:0];
            end
        end
        priority if (s14_cmd_reg == CMD_REFRACT && s14_zero_reg)
        begin
            status_next = ST_INVALID;
            for (int i = 0; i < 3; i++) clamp_next[i] = '0;
        end
        else if (s14_cmd_reg == CMD_REFRACT && s14_tir_reg)
        begin
            status_next = ST_TIR;
            for (int i = 0; i < 3; i++) clamp_next[i] = '0;
        end
        else if (|ovf)
        begin
            status_next = ST_SAT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s6_vld_reg    <= 1'b0;
            s7_vld_reg    <= 1'b0;
            s8_vld_reg    <= 1'b0;
            s9_vld_reg    <= 1'b0;
            s10_vld_reg   <= 1'b0;
            s11_vld_reg   <= 1'b0;
            s12_vld_reg   <= 1'b0;
            s13_vld_reg   <= 1'b0;
            s14_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s5_vld_reg    <= dc_vld[QW];
            s6_vld_reg    <= s5_vld_reg;
            s7_vld_reg    <= s6_vld_reg;
            s8_vld_reg    <= s7_vld_reg;
            s9_vld_reg    <= s8_vld_reg;
            s10_vld_reg   <= s9_vld_reg;
            s11_vld_reg   <= sc_vld[SR];
            s12_vld_reg   <= s11_vld_reg;
            s13_vld_reg   <= s12_vld_reg;
            s14_vld_reg   <= s13_vld_reg;
            out_valid_reg <= s14_vld_reg;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg <= cmd;
            s1_p_reg   <= index_ratio;
            for (int i = 0; i < 3; i++)
            begin
                s1_d_reg[i]  <= d_in[i];
                s1_n_reg[i]  <= n_in[i];
                s1_pr_reg[i] <= PW'(d_in[i]) * PW'(n_in[i]);
            end

            s2_cmd_reg <= s1_cmd_reg;
            s2_p_reg   <= s1_p_reg;
            s2_dot_reg <= dot_next;
            for (int i = 0; i < 3; i++)
            begin
                s2_d_reg[i] <= s1_d_reg[i];
                s2_n_reg[i] <= s1_n_reg[i];
            end

            s3_cmd_reg  <= s2_cmd_reg;
            s3_zero_reg <= (s2_p_reg == '0);
            s3_p_reg    <= s2_p_reg;
            s3_nv_reg   <= flip ? -s2_dot_reg : s2_dot_reg;
            s3_dn2_reg  <= $signed({s2_dot_reg, 1'b0});
            for (int i = 0; i < 3; i++)
            begin
                s3_d_reg[i] <= s2_d_reg[i];
                s3_n_reg[i] <= flip ? -NW'(s2_n_reg[i]) : NW'(s2_n_reg[i]);
            end

            s5_cmd_reg  <= c4_cmd;
            s5_zero_reg <= c4_zero;
            s5_dn2_reg  <= c4_dn2;
            s5_aa_reg   <= (2*QW)'(dc_quo[QW]) * (2*QW)'(dc_quo[QW]);
            s5_nn_reg   <= (2*DOTW)'(c4_nv) * (2*DOTW)'(c4_nv);
            s5_nva_reg  <= NVAW'(c4_nv) * NVAW'(c4_a);
            for (int i = 0; i < 3; i++)
            begin
                s5_d_reg[i]  <= c4_d[i];
                s5_n_reg[i]  <= c4_n[i];
                s5_da_reg[i] <= DAW'(c4_d[i]) * DAW'(c4_a);
            end

            s6_cmd_reg  <= s5_cmd_reg;
            s6_zero_reg <= s5_zero_reg;
            s6_dn2_reg  <= s5_dn2_reg;
            s6_aa_reg   <= s5_aa_reg[2*QW-1:F];
            s6_t_reg    <= t_next;
            s6_nva_reg  <= BW'(nva_t);
            for (int i = 0; i < 3; i++)
            begin
                s6_n_reg[i] <= s5_n_reg[i];
                s6_x_reg[i] <= x_next[i];
            end

            s7_cmd_reg  <= s6_cmd_reg;
            s7_zero_reg <= s6_zero_reg;
            s7_dn2_reg  <= s6_dn2_reg;
            s7_nva_reg  <= s6_nva_reg;
            s7_kl_reg   <= KLW'($signed({1'b0, s6_aa_reg[AL-1:0]})) * KLW'(s6_t_reg);
            s7_kh_reg   <= KHW'($signed({1'b0, s6_aa_reg[AAW-1:AL]})) * KHW'(s6_t_reg);
            for (int i = 0; i < 3; i++)
            begin
                s7_n_reg[i] <= s6_n_reg[i];
                s7_x_reg[i] <= s6_x_reg[i];
            end

            s8_cmd_reg  <= s7_cmd_reg;
            s8_zero_reg <= s7_zero_reg;
            s8_dn2_reg  <= s7_dn2_reg;
            s8_nva_reg  <= s7_nva_reg;
            s8_kp_reg   <= (KPW'(s7_kh_reg) <<< AL) + KPW'(s7_kl_reg);
            for (int i = 0; i < 3; i++)
            begin
                s8_n_reg[i] <= s7_n_reg[i];
                s8_x_reg[i] <= s7_x_reg[i];
            end

            s9_cmd_reg  <= s8_cmd_reg;
            s9_zero_reg <= s8_zero_reg;
            s9_dn2_reg  <= s8_dn2_reg;
            s9_nva_reg  <= s8_nva_reg;
            s9_kt_reg   <= kp_b[KPW-1:F];
            for (int i = 0; i < 3; i++)
            begin
                s9_n_reg[i] <= s8_n_reg[i];
                s9_x_reg[i] <= s8_x_reg[i];
            end

            s10_cmd_reg  <= s9_cmd_reg;
            s10_zero_reg <= s9_zero_reg;
            s10_tir_reg  <= k_next[KW-1];
            s10_dn2_reg  <= s9_dn2_reg;
            s10_nva_reg  <= s9_nva_reg;
            s10_op_reg   <= k_next[KW-1] ? '0 : XW'({k_next[KW-2:0], {F{1'b0}}});
            for (int i = 0; i < 3; i++)
            begin
                s10_n_reg[i] <= s9_n_reg[i];
                s10_x_reg[i] <= s9_x_reg[i];
            end

            s11_cmd_reg  <= c11_cmd;
            s11_zero_reg <= c11_zero;
            s11_tir_reg  <= c11_tir;
            s11_b_reg    <= b_next;
            for (int i = 0; i < 3; i++)
            begin
                s11_n_reg[i] <= c11_n[i];
                s11_x_reg[i] <= c11_x[i];
            end

            s12_cmd_reg  <= s11_cmd_reg;
            s12_zero_reg <= s11_zero_reg;
            s12_tir_reg  <= s11_tir_reg;
            for (int i = 0; i < 3; i++)
            begin
                s12_x_reg[i]  <= s11_x_reg[i];
                s12_nb_reg[i] <= NBW'(s11_n_reg[i]) * NBW'(s11_b_reg);
            end

            s13_cmd_reg  <= s12_cmd_reg;
            s13_zero_reg <= s12_zero_reg;
            s13_tir_reg  <= s12_tir_reg;
            for (int i = 0; i < 3; i++)
            begin
                s13_x_reg[i]   <= s12_x_reg[i];
                s13_nbt_reg[i] <= nb_b[i][NBW-1:F];
            end

            s14_cmd_reg  <= s13_cmd_reg;
            s14_zero_reg <= s13_zero_reg;
            s14_tir_reg  <= s13_tir_reg;
            for (int i = 0; i < 3; i++)
            begin
                s14_r_reg[i] <= RW'(s13_x_reg[i]) - RW'(s13_nbt_reg[i]);
            end

            status_reg <= status_next;
            for (int i = 0; i < 3; i++)
            begin
                out_c_reg[i] <= clamp_next[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_c_reg[0];
    assign out_y     = out_c_reg[1];
    assign out_z     = out_c_reg[2];
    assign status    = status_reg;

endmodule

### hdl/rrd_checker.sv
// ----------------------------------------------------------------------------
// rrd_checker
// Port-level checks of the ray reflect/refract direction unit.
// ----------------------------------------------------------------------------
module rrd_checker #(
    parameter int COMP_WIDTH = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [COMP_WIDTH-1:0] out_x,
    input logic signed [COMP_WIDTH-1:0] out_y,
    input logic signed [COMP_WIDTH-1:0] out_z,
    input logic [1:0]                   status
);
    import rrd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_y)
                                    && $stable(out_z) && $stable(status))
        else $error("output payload changed while stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output stalled");

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_TIR || status == ST_INVALID)
        |-> out_x == '0 && out_y == '0 && out_z == '0)
        else $error("nonzero vector with reflection or invalid status");

endmodule

bind ray_reflect_refract_direction rrd_checker #(.COMP_WIDTH(COMP_WIDTH)) u_rrd_checker (.*);

### bench/ray_reflect_refract_direction_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_reflect_refract_direction_tb
// Streams reflect and refract requests through the direction unit with random
// stalls on both sides and checks every result against a fixed-point predictor.
// ----------------------------------------------------------------------------
module ray_reflect_refract_direction_tb;

    import rrd_pkg::*;

    localparam int CW = 16;
    localparam int FB = 14;
    localparam longint LIM = 64'sd4611686018427387903;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        status_t              st;
    } dir_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd = CMD_REFLECT;
    logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic signed [CW-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
    logic [IDX_W-1:0] index_ratio = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [CW-1:0] out_x, out_y, out_z;
    logic [1:0] status;

    dir_result_t pending_dirs[$];
    int  errors = 0;
    bit  calm = 1'b0;
    bit  clamped;

    ray_reflect_refract_direction uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .index_ratio(index_ratio),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint clamp62(logic signed [127:0] v);
        if (v > LIM)
        begin
            clamped = 1'b1;
            return LIM;
        end
        if (v < -LIM)
        begin
            clamped = 1'b1;
            return -LIM;
        end
        return longint'(v);
    endfunction

    function automatic longint add_s(longint a, longint b);
        return clamp62(128'(a) + 128'(b));
    endfunction

    function automatic longint sub_s(longint a, longint b);
        return clamp62(128'(a) - 128'(b));
    endfunction

    // truncate toward zero; magnitude clamps to LIM
    function automatic longint fmul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0] m;
        p = 128'(a) * 128'(b);
        m = (p < 0) ? 128'(-p) : 128'(p);
        m = m >> FB;
        if (m > 128'(LIM))
        begin
            clamped = 1'b1;
            m = 128'(LIM);
        end
        return (p < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fdot(longint u[3], longint v[3]);
        return add_s(add_s(fmul(u[0], v[0]), fmul(u[1], v[1])), fmul(u[2], v[2]));
    endfunction

    function automatic longint froot(longint k);
        longint kmax;
        logic [63:0] x, res, b;
        kmax = LIM >>> FB;
        if (k > kmax)
        begin
            clamped = 1'b1;
            k = kmax;
        end
        x = 64'(k) << FB;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic signed [CW-1:0] to_comp(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            clamped = 1'b1;
            v = hi;
        end
        if (v < lo)
        begin
            clamped = 1'b1;
            v = lo;
        end
        return v[CW-1:0];
    endfunction

    function automatic dir_result_t predict_direction(logic op, logic signed [CW-1:0] dv[3],
            logic signed [CW-1:0] nvv[3], logic [IDX_W-1:0] idx);
        longint d[3], n[3], r[3];
        longint dn, nv, a, k, b, one;
        dir_result_t res;
        clamped = 1'b0;
        res.st = ST_OK;
        one = longint'(1) <<< FB;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = dv[i];
            n[i] = nvv[i];
            r[i] = 0;
        end
        if (op == CMD_REFLECT)
        begin
            dn = fdot(d, n);
            dn = add_s(dn, dn);
            for (int i = 0; i < 3; i++) r[i] = sub_s(d[i], fmul(n[i], dn));
        end
        else if (idx == 0)
            res.st = ST_INVALID;
        else
        begin
            nv = fdot(n, d);
            if (nv > 0)
            begin
                nv = -nv;
                for (int i = 0; i < 3; i++) n[i] = -n[i];
            end
            a = (longint'(1) <<< (FB + IDX_FRAC)) / longint'(idx);
            k = sub_s(one, fmul(fmul(a, a), sub_s(one, fmul(nv, nv))));
            if (k < 0)
                res.st = ST_TIR;
            else
            begin
                b = add_s(fmul(nv, a), froot(k));
                for (int i = 0; i < 3; i++) r[i] = sub_s(fmul(d[i], a), fmul(n[i], b));
            end
        end
        res.x = to_comp(r[0]);
        res.y = to_comp(r[1]);
        res.z = to_comp(r[2]);
        if (res.st == ST_OK && clamped) res.st = ST_SAT;
        return res;
    endfunction

    task automatic send_ray(logic op, logic signed [CW-1:0] dx, logic signed [CW-1:0] dy,
            logic signed [CW-1:0] dz, logic signed [CW-1:0] nx, logic signed [CW-1:0] ny,
            logic signed [CW-1:0] nz, logic [IDX_W-1:0] idx);
        logic signed [CW-1:0] dv[3], nvv[3];
        dv = '{dx, dy, dz};
        nvv = '{nx, ny, nz};
        while (!calm && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= op;
        dir_x <= dx; dir_y <= dy; dir_z <= dz;
        norm_x <= nx; norm_y <= ny; norm_z <= nz;
        index_ratio <= idx;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_dirs.push_back(predict_direction(op, dv, nvv, idx));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= calm || ($urandom_range(99) >= 15);
    end

    always @(posedge clk)
    begin
        dir_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dirs.size() == 0)
            begin
                $display("%0t: unexpected result %0d %0d %0d st %0d",
                         $time, out_x, out_y, out_z, status);
                errors++;
            end
            else
            begin
                e = pending_dirs.pop_front();
                if (out_x !== e.x || out_y !== e.y || out_z !== e.z || status !== e.st)
                begin
                    $display("%0t: expected %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                             $time, e.x, e.y, e.z, e.st, out_x, out_y, out_z, status);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return CW'($signed($urandom_range(32768)) - 16384);
            2: return CW'($signed($urandom_range(600)) - 300);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1: return $urandom_range(1) ? 16'd1 : 16'd2;
            2, 3: return IDX_W'($urandom_range(8192, 2048));
            default: return IDX_W'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        send_ray(CMD_REFLECT, 16'sh7FFF, 16'sh8000, 0, 16'sh8000, 16'sh7FFF, 0, 0);
        send_ray(CMD_REFLECT, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'hFFFF);
        send_ray(CMD_REFLECT, 16'sd16384, 0, 0, 0, 16'sd16384, 0, 0);
        send_ray(CMD_REFLECT, 0, -16'sd16384, 0, 0, 16'sd16384, 0, 0);
        send_ray(CMD_REFRACT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                 16'sh7FFF, 16'hFFFF);
        send_ray(CMD_REFRACT, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'd1);
    endtask

    task automatic test_refract_cases();
        // zero index
        send_ray(CMD_REFRACT, 0, -16'sd16384, 0, 0, 16'sd16384, 0, 16'd0);
        // straight through, index one
        send_ray(CMD_REFRACT, 0, -16'sd16384, 0, 0, 16'sd16384, 0, 16'd4096);
        // normal flip, then a case that needs no flip
        send_ray(CMD_REFRACT, 16'sd8000, -16'sd12000, 0, 0, -16'sd16384, 0, 16'd6000);
        send_ray(CMD_REFRACT, 16'sd8000, 16'sd12000, 0, 16'sh8000, 16'sh8000, 0, 16'd3000);
        // grazing into lower index: total internal reflection
        send_ray(CMD_REFRACT, 16'sd16000, -16'sd3000, 0, 0, 16'sd16384, 0, 16'd2731);
        send_ray(CMD_REFRACT, 16'sd16384, 0, 0, 0, 16'sd16384, 0, 16'd1);
        // huge reciprocal: total internal reflection, then a plain refraction
        send_ray(CMD_REFRACT, 16'sd1000, -16'sd16000, 0, 0, 16'sd16384, 0, 16'd1);
        send_ray(CMD_REFRACT, 16'sd5000, -16'sd9000, 16'sd7000, 16'sd300, 16'sd16000,
                 -16'sd200, 16'd5461);
    endtask

    task automatic test_random(int count);
        logic signed [CW-1:0] c[6];
        for (int i = 0; i < count; i++)
        begin
            calm = (i >= count / 2) && (i < count / 2 + 150);
            foreach (c[j]) c[j] = rand_comp();
            send_ray(1'($urandom_range(1)), c[0], c[1], c[2], c[3], c[4], c[5],
                     rand_index());
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int guard;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_refract_cases();
        test_random(1240);
        in_valid <= 1'b0;
        guard = 0;
        while (pending_dirs.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_dirs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
